>>> hdl/egsd_pkg.sv
// Shared types and the signed unmapping function for the Elias gamma decoder.
`default_nettype none

package egsd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ValueW = 32;
  localparam int unsigned CountW = 5;
  localparam int unsigned BitIdxW = 3;

  // One decoded result as it leaves the back end
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              error;
    logic              last;
  } egsd_result_t;

  // Odd n gives (n-1)/2, even n gives -(n/2)
  function automatic logic [ValueW-1:0] egsd_unmap(input logic [ValueW-1:0] n);
    logic [ValueW-1:0] half;
    half = {1'b0, n[ValueW-1:1]};
    return n[0] ? half : ({ValueW{1'b0}} - half);
  endfunction

endpackage

`default_nettype wire

>>> hdl/egsd_byte_fifo.sv
// Two-entry byte queue between the input channel and the bit-serial decoder.
`default_nettype none

module egsd_byte_fifo (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        wr_valid,
  output logic                       wr_ready,
  input  wire  [egsd_pkg::ByteW-1:0] wr_data,
  output logic                       rd_valid,
  input  wire                        rd_pop,
  output logic [egsd_pkg::ByteW-1:0] rd_data
);
  import egsd_pkg::*;

  logic [ByteW-1:0] mem_r [2];
  logic             wr_ptr_r;
  logic             wr_ptr_nxt;
  logic             rd_ptr_r;
  logic             rd_ptr_nxt;
  logic [1:0]       count_r;
  logic [1:0]       count_nxt;
  logic             push;
  logic             pop;

  // Report space and head entry
  always_comb begin
    wr_ready = (count_r != 2'd2);
    rd_valid = (count_r != 2'd0);
    rd_data  = mem_r[rd_ptr_r];
    push     = wr_valid && wr_ready;
    pop      = rd_pop && rd_valid;
  end

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the incoming byte
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

>>> hdl/egsd_back.sv
// Bit-serial Elias gamma decoder with a pending result slot and an output register.
`default_nettype none

module egsd_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          byte_valid,
  input  wire  [egsd_pkg::ByteW-1:0]   byte_data,
  output logic                         byte_pop,
  output logic                         res_valid,
  input  wire                          res_ready,
  output egsd_pkg::egsd_result_t       res
);
  import egsd_pkg::*;

  // Byte walker
  logic               busy_r,  busy_nxt;
  logic [ByteW-1:0]   sh_r,    sh_nxt;
  logic [BitIdxW-1:0] idx_r,   idx_nxt;
  // Decode state
  logic               counting_r, counting_nxt;
  logic [CountW-1:0]  rem_r,      rem_nxt;
  logic [ValueW-1:0]  buf_r,      buf_nxt;
  // Pending result, held until the next one or the byte's end shows if it is last
  logic               pend_valid_r, pend_valid_nxt;
  logic               pend_final_r, pend_final_nxt;
  logic               pend_err_r,   pend_err_nxt;
  logic [ValueW-1:0]  pend_val_r,   pend_val_nxt;
  // Output register
  logic               out_valid_r,  out_valid_nxt;
  egsd_result_t       out_r,        out_nxt;

  logic               cur_bit;
  logic               last_bit;
  logic               emit;
  logic               emit_err;
  logic [ValueW-1:0]  emit_val;
  logic               step_counting;
  logic [CountW-1:0]  step_rem;
  logic [ValueW-1:0]  step_buf;
  logic               move_ok;
  logic               stall;
  logic               step;
  logic               push;
  logic               load;

  // Decode one bit from the current state
  always_comb begin
    cur_bit       = sh_r[ByteW-1];
    emit          = 1'b0;
    emit_err      = 1'b0;
    emit_val      = '0;
    step_counting = counting_r;
    step_rem      = rem_r;
    step_buf      = buf_r;
    if (counting_r) begin
      if (!cur_bit) begin
        if (rem_r == {CountW{1'b1}}) begin
          emit     = 1'b1;
          emit_err = 1'b1;
          step_rem = '0;
        end else begin
          step_rem = rem_r + CountW'(1);
        end
      end else begin
        step_buf = {{(ValueW-1){1'b0}}, 1'b1};
        if (rem_r == '0) begin
          emit     = 1'b1;
          emit_val = egsd_unmap(step_buf);
        end else begin
          step_counting = 1'b0;
        end
      end
    end else begin
      step_buf = {buf_r[ValueW-2:0], cur_bit};
      step_rem = rem_r - CountW'(1);
      if (step_rem == '0) begin
        emit          = 1'b1;
        emit_val      = egsd_unmap(step_buf);
        step_counting = 1'b1;
      end
    end
  end

  // Handshake between bit steps, pending slot and output register
  always_comb begin
    last_bit = (idx_r == {BitIdxW{1'b1}});
    move_ok  = !out_valid_r || res_ready;
    stall    = emit && pend_valid_r && !move_ok;
    step     = busy_r && !stall;
    push     = pend_valid_r && move_ok && (pend_final_r || (busy_r && emit));
    load     = byte_valid && (!busy_r || (step && last_bit));
    byte_pop = load;
  end

  // Next state for walker, decoder, pending slot and output
  always_comb begin
    busy_nxt       = busy_r;
    sh_nxt         = sh_r;
    idx_nxt        = idx_r;
    counting_nxt   = counting_r;
    rem_nxt        = rem_r;
    buf_nxt        = buf_r;
    pend_valid_nxt = pend_valid_r;
    pend_final_nxt = pend_final_r;
    pend_err_nxt   = pend_err_r;
    pend_val_nxt   = pend_val_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;

    // Advance through the byte, or take a fresh one
    if (load) begin
      busy_nxt = 1'b1;
      sh_nxt   = byte_data;
      idx_nxt  = '0;
    end else if (step) begin
      sh_nxt  = {sh_r[ByteW-2:0], 1'b0};
      idx_nxt = idx_r + BitIdxW'(1);
      if (last_bit) begin
        busy_nxt = 1'b0;
      end
    end

    if (step) begin
      counting_nxt = step_counting;
      rem_nxt      = step_rem;
      buf_nxt      = step_buf;
    end

    // Drop the pending result into the output register
    if (push) begin
      out_valid_nxt     = 1'b1;
      out_nxt.value     = pend_val_r;
      out_nxt.error     = pend_err_r;
      out_nxt.last      = pend_final_r;
      pend_valid_nxt    = 1'b0;
      pend_final_nxt    = 1'b0;
    end else if (res_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Hold the new result; mark it final at the end of the byte
    if (step && emit) begin
      pend_valid_nxt = 1'b1;
      pend_val_nxt   = emit_val;
      pend_err_nxt   = emit_err;
      pend_final_nxt = last_bit;
    end else if (step && last_bit && pend_valid_nxt) begin
      pend_final_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      idx_r        <= '0;
      counting_r   <= 1'b1;
      rem_r        <= '0;
      buf_r        <= '0;
      pend_valid_r <= 1'b0;
      pend_final_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      idx_r        <= idx_nxt;
      counting_r   <= counting_nxt;
      rem_r        <= rem_nxt;
      buf_r        <= buf_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_final_r <= pend_final_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    pend_err_r <= pend_err_nxt;
    pend_val_r <= pend_val_nxt;
    out_r      <= out_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

`default_nettype wire

>>> hdl/elias_gamma_signed_decoder_unit.sv
// Top level of the Elias gamma decoder with signed unmapping.
//
// The slave channel takes one bitstream byte per beat on in_tdata, MSB first.
// The master channel gives one decoded value per beat: out_tdata is the
// signed value, out_tuser flags a zero prefix longer than 31 bits (value 0),
// and out_tlast marks the final result caused by an input byte. A byte that
// completes no code word gives no beat at all.
// Bytes enter a two-entry queue, and the decoder walks each one a bit per
// cycle while the pending slot does not stall it; the next byte is loaded
// in the same cycle as the last bit of the previous one is decoded. Each
// result is held in a pending slot until the next result or the end of its
// byte shows whether it carries tlast, then moves to the output register, so
// a code word passes the queue, the bit walker, the pending slot and the
// output register before out_tvalid rises.
// A stalled receiver holds the output beat; decoding goes on until the
// pending slot is also full, and then the queue fills and in_tready drops.
// Reset (rst_n low, synchronous) empties the queue, drops held results and
// returns the decoder to counting leading zeros with a zero count.
`default_nettype none

module elias_gamma_signed_decoder_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [31:0] out_tdata,  // [31:0] value
  output logic [0:0]  out_tuser,  // [0] error
  output logic        out_tlast
);
  import egsd_pkg::*;

  logic             q_valid;
  logic             q_pop;
  logic [ByteW-1:0] q_data;
  egsd_result_t     res;

  // Front: byte queue
  egsd_byte_fifo u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (in_tvalid),
    .wr_ready (in_tready),
    .wr_data  (in_tdata),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_data)
  );

  // Back: bit-serial decode and result staging
  egsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (q_valid),
    .byte_data  (q_data),
    .byte_pop   (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = res.value;
  assign out_tuser = res.error;
  assign out_tlast = res.last;

  // An error beat carries a zero value
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> (out_tdata == '0))
    else $error("error beat with nonzero value");

  // No beat is offered right after reset
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> !out_tvalid)
    else $error("output valid after reset");

  // A full queue always has a byte waiting for the decoder
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> q_valid)
    else $error("input stalled with empty queue");

endmodule

`default_nettype wire
